// ===== sv/motion_triggered_capture_assert.svh =====
// Assertion macros used by the motion capture checker.
`ifndef MOTION_TRIGGERED_CAPTURE_ASSERT_SVH
`define MOTION_TRIGGERED_CAPTURE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define MTC_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("motion capture check failed");

// Check a consequent in the cycle after its antecedent.
`define MTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("motion capture check failed");

`endif

// ===== sv/mtc_pkg.sv =====
// Shared types and constants of the motion capture block.
package mtc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W     = 4;
    localparam int MODE_W     = 2;
    localparam int THR_W      = 15;
    localparam int WLEN_W     = 16;
    localparam int RFR_W      = 16;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_THRESHOLD,
        REG_WINDOW_LEN,
        REG_REFRACT
    } reg_idx_t;

    localparam logic [MODE_W-1:0] MODE_STREAM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ABOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET       = MODE_STREAM;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 15'd1536;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 16'd1500;
    localparam logic [RFR_W-1:0]  REFRACT_RESET    = 16'd751;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [THR_W-1:0]  threshold;
        logic [WLEN_W-1:0] window_len;
        logic [RFR_W-1:0]  refract_items;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic square;
        logic sum;
        logic root_step;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic motion;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/mtc_regs.sv =====
// APB configuration registers of the motion capture block.
module mtc_regs import mtc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_MODE:       cfg_next.mode          = pwdata[MODE_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold     = pwdata[THR_W-1:0];
                REG_WINDOW_LEN: cfg_next.window_len    = pwdata[WLEN_W-1:0];
                REG_REFRACT:    cfg_next.refract_items = pwdata[RFR_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:       prdata = CFG_DATA_W'(cfg_reg.mode);
            REG_THRESHOLD:  prdata = CFG_DATA_W'(cfg_reg.threshold);
            REG_WINDOW_LEN: prdata = CFG_DATA_W'(cfg_reg.window_len);
            REG_REFRACT:    prdata = CFG_DATA_W'(cfg_reg.refract_items);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_RESET;
            cfg_reg.threshold     <= THRESHOLD_RESET;
            cfg_reg.window_len    <= WINDOW_LEN_RESET;
            cfg_reg.refract_items <= REFRACT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/mtc_datapath.sv =====
// Datapath: sample hold, squares, bit-serial square root and output register.
module mtc_datapath import mtc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  logic [THR_W-1:0] threshold,
    input  dp_cmd_t          cmd,
    output dp_status_t       status
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int SUMW = 2 * SW;
    localparam int REMW = SW + 2;
    localparam int CMPW = (SW > THR_W) ? SW : THR_W;

    logic signed [SW-1:0]   x_reg, y_reg, z_reg;
    logic signed [SUMW-1:0] prod_x, prod_y, prod_z;
    logic [SUMW-1:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SUMW-1:0]        rad_reg, rad_next;
    logic [REMW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]          root_reg, root_next;
    logic [REMW-1:0]        rem_sh, trial;
    logic                   fits;
    logic [SW-1:0]          out_x_reg, out_y_reg, out_z_reg, out_mag_reg;
    logic                   out_last_reg;
    logic                   out_valid_reg, out_valid_next;

    assign prod_x = x_reg * x_reg;
    assign prod_y = y_reg * y_reg;
    assign prod_z = z_reg * z_reg;

    assign rem_sh = {rem_reg[SW-1:0], rad_reg[SUMW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (cmd.sum) begin
            rad_next  = sq_x_reg + sq_y_reg + sq_z_reg;
            rem_next  = '0;
            root_next = '0;
        end else if (cmd.root_step) begin
            rad_next  = {rad_reg[SUMW-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[SW-2:0], fits};
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign status.motion   = CMPW'(root_reg) > CMPW'(threshold);
    assign status.out_busy = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_mag_reg, out_z_reg, out_y_reg, out_x_reg});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= s_tdata[SW-1:0];
            y_reg <= s_tdata[2*SW-1:SW];
            z_reg <= s_tdata[3*SW-1:2*SW];
        end
        if (cmd.square) begin
            sq_x_reg <= prod_x;
            sq_y_reg <= prod_y;
            sq_z_reg <= prod_z;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (cmd.out_load) begin
            out_x_reg    <= x_reg;
            out_y_reg    <= y_reg;
            out_z_reg    <= z_reg;
            out_mag_reg  <= root_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/mtc_ctrl.sv =====
// Controller: item sequencing and the triggered-window capture state.
module mtc_ctrl import mtc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  cfg_t       cfg,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int STEP_W = $clog2(SAMPLE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DECIDE
    } state_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LOG,
        PH_LAST,
        PH_REFRACT
    } phase_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    phase_t             phase_reg, phase_next, phase_c;
    logic [WLEN_W-1:0]  wcount_reg, wcount_next, wcount_c, wcount_inc, wl_m1;
    logic [RFR_W-1:0]   rleft_reg, rleft_next, rleft_c, rleft_dec;
    logic               emit, last;

    assign s_tready   = (state_reg == S_IDLE);
    assign wcount_inc = wcount_reg + 1'b1;
    assign wl_m1      = (cfg.window_len < WLEN_W'(2)) ? WLEN_W'(1)
                                                      : cfg.window_len - 1'b1;
    assign rleft_dec  = (rleft_reg != '0) ? rleft_reg - 1'b1 : rleft_reg;

    // Work out what this item would do to the capture state.
    always_comb begin
        emit     = 1'b0;
        last     = 1'b0;
        phase_c  = phase_reg;
        wcount_c = wcount_reg;
        rleft_c  = rleft_reg;
        case (cfg.mode)
            MODE_STREAM: emit = 1'b1;
            MODE_ABOVE:  emit = status.motion;
            MODE_RECORD: begin
                case (phase_reg)
                    PH_WAIT: begin
                        if (status.motion) begin
                            phase_c = PH_LOG;
                        end
                    end
                    PH_LOG: begin
                        emit     = 1'b1;
                        wcount_c = wcount_inc;
                        if (wcount_inc >= wl_m1) begin
                            phase_c = PH_LAST;
                        end
                    end
                    PH_LAST: begin
                        emit     = 1'b1;
                        last     = 1'b1;
                        wcount_c = '0;
                        if (cfg.refract_items == '0) begin
                            phase_c = PH_WAIT;
                        end else begin
                            rleft_c = cfg.refract_items;
                            phase_c = PH_REFRACT;
                        end
                    end
                    PH_REFRACT: begin
                        rleft_c = rleft_dec;
                        if (rleft_dec == '0) begin
                            phase_c = PH_WAIT;
                        end
                    end
                    default: phase_c = phase_reg;
                endcase
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        wcount_next = wcount_reg;
        rleft_next  = rleft_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                step_next  = STEP_W'(SAMPLE_WIDTH - 1);
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = S_DECIDE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_DECIDE: begin
                // Hold while a result must go out and the output is still full.
                if (!(emit && status.out_busy)) begin
                    cmd.out_load = emit;
                    cmd.out_last = last;
                    phase_next   = phase_c;
                    wcount_next  = wcount_c;
                    rleft_next   = rleft_c;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            phase_reg  <= PH_WAIT;
            wcount_reg <= '0;
            rleft_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            wcount_reg <= wcount_next;
            rleft_reg  <= rleft_next;
        end
    end

endmodule

// ===== sv/motion_triggered_capture.sv =====
// Top level of the motion-triggered accelerometer capture block.
// Each request on the s_ channel is one x/y/z sample; the block forms its
// magnitude as the floor square root of the sum of squares and, by the mode
// register, streams every sample, only those above threshold, or records
// windows of window_len (at least two) samples after a trigger sample (m_tlast
// on the last one), then drops refract_items samples; other modes drop all.
// It takes no new sample until it is through with the last: it loads,
// squares, sums, runs the square root unit that resolves one root bit per
// cycle and decides; a result waits in the output register, and only a new
// result blocked by a full, stalled output register holds up the decision.
// Registers sit on the APB port at byte addresses 0x0 mode, 0x4 threshold,
// 0x8 window_len, 0xC refract_items.
module motion_triggered_capture import mtc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // sample_x, sample_y, sample_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // out_x, out_y, out_z, magnitude
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    mtc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtc_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg      (cfg),
        .status   (status),
        .cmd      (cmd)
    );

    mtc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .threshold (cfg.threshold),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/mtc_checker.sv =====
// Port-level checker of the motion capture block and its bind.
`include "motion_triggered_capture_assert.svh"

module mtc_checker import mtc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int OUT_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int SQW = 2 * SW + 2;

    logic signed [SW-1:0]    cx, cy, cz;
    logic [SW-1:0]           cmag;
    logic signed [2*SW-1:0]  px, py, pz;
    logic [SQW-1:0]          sum_sq, mag_sq, mag1_sq;

    assign cx      = m_tdata[SW-1:0];
    assign cy      = m_tdata[2*SW-1:SW];
    assign cz      = m_tdata[3*SW-1:2*SW];
    assign cmag    = m_tdata[4*SW-1:3*SW];
    assign px      = cx * cx;
    assign py      = cy * cy;
    assign pz      = cz * cz;
    assign sum_sq  = SQW'(unsigned'(px)) + SQW'(unsigned'(py)) + SQW'(unsigned'(pz));
    assign mag_sq  = SQW'(cmag) * SQW'(cmag);
    assign mag1_sq = (SQW'(cmag) + 1'b1) * (SQW'(cmag) + 1'b1);

    `MTC_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
    `MTC_ASSERT_HOLD(a_no_instant_result, $rose(m_tvalid), !$past(s_tvalid && s_tready))
    `MTC_ASSERT_HOLD(a_magnitude_floor, m_tvalid, (mag_sq <= sum_sq) && (mag1_sq > sum_sq))
    `MTC_ASSERT_NEXT(a_stalled_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind motion_triggered_capture mtc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_motion_triggered_capture.sv =====
// Self-checking testbench of the motion-triggered capture block with its own capture predictor.
`timescale 1ns / 100ps

module tb_motion_triggered_capture;
    import mtc_pkg::*;

    localparam int SW              = 16;
    localparam int IN_W            = ((3 * SW + 7) / 8) * 8;
    localparam int OUT_W           = ((4 * SW + 7) / 8) * 8;
    localparam int CLK_PERIOD      = 10;
    localparam int SETTLE_CYCLES   = 2 * (SW + 4);
    localparam int IDLE_LIMIT      = 4000;
    localparam int RAND_PHASES     = 15;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int MAX_REPORTS     = 10;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CAP_WAIT,
        CAP_LOG,
        CAP_LAST,
        CAP_REFRACT
    } capture_phase_e;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
    } sample_t;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
        logic [SW-1:0]        mag;
        logic                 last;
    } capture_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;   // sample_x, sample_y, sample_z
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;         // out_x, out_y, out_z, magnitude
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t           cfg_model;
    capture_phase_e cap_phase;
    logic [15:0]    win_count;
    logic [15:0]    refract_left;

    sample_t  pending_samples[$];
    capture_t expected_caps[$];
    sample_t  offered;
    bit       item_offered   = 1'b0;
    bit       send_gaps_on   = 1'b1;
    bit       recv_stalls_on = 1'b1;
    int       send_gap       = 0;
    int       stall_left     = 0;
    int       mismatches     = 0;
    int       idle_cycles    = 0;

    motion_triggered_capture #(
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [SW-1:0] floor_magnitude(logic signed [SW-1:0] x,
                                                      logic signed [SW-1:0] y,
                                                      logic signed [SW-1:0] z);
        longint sq;
        longint root;
        longint trial;
        sq   = longint'(x) * longint'(x) + longint'(y) * longint'(y)
             + longint'(z) * longint'(z);
        root = 0;
        for (int b = SW - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq) root = trial;
        end
        return root[SW-1:0];
    endfunction

    task automatic predict_capture(input sample_t s);
        logic [SW-1:0]     mag;
        logic              motion;
        logic [WLEN_W-1:0] wlen;
        capture_t          c;
        mag    = floor_magnitude(s.x, s.y, s.z);
        motion = mag > cfg_model.threshold;
        wlen   = (cfg_model.window_len < 2) ? WLEN_W'(2) : cfg_model.window_len;
        c.x    = s.x;
        c.y    = s.y;
        c.z    = s.z;
        c.mag  = mag;
        c.last = 1'b0;
        case (cfg_model.mode)
            MODE_STREAM: expected_caps.push_back(c);
            MODE_ABOVE: if (motion) expected_caps.push_back(c);
            MODE_RECORD: begin
                case (cap_phase)
                    CAP_WAIT: if (motion) cap_phase = CAP_LOG;
                    CAP_LOG: begin
                        expected_caps.push_back(c);
                        win_count = win_count + 16'd1;
                        if (win_count >= wlen - 1) cap_phase = CAP_LAST;
                    end
                    CAP_LAST: begin
                        c.last = 1'b1;
                        expected_caps.push_back(c);
                        win_count = '0;
                        if (cfg_model.refract_items == 0) begin
                            cap_phase = CAP_WAIT;
                        end else begin
                            refract_left = cfg_model.refract_items;
                            cap_phase    = CAP_REFRACT;
                        end
                    end
                    default: begin
                        if (refract_left > 0) refract_left = refract_left - 16'd1;
                        if (refract_left == 0) cap_phase = CAP_WAIT;
                    end
                endcase
            end
            default: ;
        endcase
    endtask

    function automatic int send_gap_len();
        if (!send_gaps_on || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge aclk) begin : drive_samples
        logic valid_n;
        if (!aresetn) begin
            valid_n      = 1'b0;
            send_gap     = 0;
            item_offered = 1'b0;
        end else begin
            valid_n = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_capture(offered);
                item_offered = 1'b0;
                valid_n      = 1'b0;
            end
            if (!valid_n) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_samples.size() > 0) begin
                    offered      = pending_samples.pop_front();
                    s_tdata      <= IN_W'({offered.z, offered.y, offered.x});
                    item_offered = 1'b1;
                    valid_n      = 1'b1;
                    send_gap     = send_gap_len();
                    if ($urandom_range(0, 49) == 0) send_gaps_on = !send_gaps_on;
                end
            end
        end
        s_tvalid <= valid_n;
    end

    always @(posedge aclk) begin : check_captures
        capture_t got;
        capture_t want;
        logic     rdy_n;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[SW-1:0];
            got.y    = m_tdata[2*SW-1:SW];
            got.z    = m_tdata[3*SW-1:2*SW];
            got.mag  = m_tdata[4*SW-1:3*SW];
            got.last = m_tlast;
            if (expected_caps.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected capture: x=%0d y=%0d z=%0d mag=%0d last=%0b",
                             got.x, got.y, got.z, got.mag, got.last);
                mismatches++;
            end else begin
                want = expected_caps.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.mag !== want.mag || got.last !== want.last) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"capture mismatch: expected x=%0d y=%0d z=%0d mag=%0d ",
                                  "last=%0b, got x=%0d y=%0d z=%0d mag=%0d last=%0b"},
                                 want.x, want.y, want.z, want.mag, want.last,
                                 got.x, got.y, got.z, got.mag, got.last);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            rdy_n = 1'b0;
        end else if (recv_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 3);
            rdy_n = 1'b0;
        end else begin
            rdy_n = 1'b1;
        end
        if ($urandom_range(0, 199) == 0) recv_stalls_on = !recv_stalls_on;
        m_tready <= rdy_n;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cfg_model.mode          = value[MODE_W-1:0];
            REG_THRESHOLD:  cfg_model.threshold     = value[THR_W-1:0];
            REG_WINDOW_LEN: cfg_model.window_len    = value[WLEN_W-1:0];
            REG_REFRACT:    cfg_model.refract_items = value[RFR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_sent();
        while (pending_samples.size() > 0 || item_offered) @(posedge aclk);
    endtask

    task automatic drain_captures();
        wait_sent();
        while (expected_caps.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_capture(input logic [MODE_W-1:0] md, input int thr,
                                     input int wl, input int rf);
        drain_captures();
        write_reg(REG_MODE, CFG_DATA_W'(md));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_WINDOW_LEN, CFG_DATA_W'(wl));
        write_reg(REG_REFRACT, CFG_DATA_W'(rf));
    endtask

    task automatic queue_sample(input int x, input int y, input int z);
        sample_t s;
        s.x = SW'(x);
        s.y = SW'(y);
        s.z = SW'(z);
        pending_samples.push_back(s);
    endtask

    function automatic logic signed [SW-1:0] signed_axis(int v);
        if (v > 32767) v = 32767;
        if (v < 0) v = 0;
        return $urandom_range(0, 1) ? SW'(-v) : SW'(v);
    endfunction

    function automatic logic signed [SW-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return SW'(-32768);
            1: return SW'(32767);
            2: return SW'(-1);
            default: return '0;
        endcase
    endfunction

    function automatic sample_t random_sample(int thr);
        sample_t s;
        int      sel;
        int      pick;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            s.x = signed_axis($urandom_range(0, thr / 2));
            s.y = signed_axis($urandom_range(0, thr / 2));
            s.z = signed_axis($urandom_range(0, thr / 2));
        end else if (sel < 7) begin
            s.x = SW'($urandom);
            s.y = SW'($urandom);
            s.z = SW'($urandom);
        end else if (sel == 7) begin
            s.x  = '0;
            s.y  = '0;
            s.z  = '0;
            pick = $urandom_range(0, 2);
            if (pick == 0) s.x = signed_axis(thr + $urandom_range(0, 2) - 1);
            else if (pick == 1) s.y = signed_axis(thr + $urandom_range(0, 2) - 1);
            else s.z = signed_axis(thr + $urandom_range(0, 2) - 1);
        end else if (sel == 8) begin
            s.x = pick_extreme();
            s.y = pick_extreme();
            s.z = pick_extreme();
        end else begin
            s.x = signed_axis($urandom_range(0, 2 * thr + 2));
            s.y = signed_axis($urandom_range(0, 2 * thr + 2));
            s.z = signed_axis($urandom_range(0, 2 * thr + 2));
        end
        return s;
    endfunction

    initial begin
        logic [MODE_W-1:0] md;
        int                thr;
        int                wl;
        int                rf;
        int                sel;
        bit                split;

        cfg_model.mode          = MODE_RESET;
        cfg_model.threshold     = THRESHOLD_RESET;
        cfg_model.window_len    = WINDOW_LEN_RESET;
        cfg_model.refract_items = REFRACT_RESET;
        cap_phase               = CAP_WAIT;
        win_count               = '0;
        refract_left            = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stream everything, field extremes
        configure_capture(MODE_RESET, THRESHOLD_RESET, WINDOW_LEN_RESET, REFRACT_RESET);
        queue_sample(0, 0, 0);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        queue_sample(-1, -1, -1);
        queue_sample(21845, -21846, 32767);
        queue_sample(32767, -32768, 0);

        // threshold is strict: equal magnitude is no motion
        configure_capture(MODE_ABOVE, 1536, 1500, 751);
        queue_sample(1536, 0, 0);
        queue_sample(1537, 0, 0);
        queue_sample(0, -1537, 0);
        queue_sample(887, 887, 887);

        configure_capture(MODE_ABOVE, 0, 1500, 751);
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 1);

        // short window acts as two samples, no refractory period
        configure_capture(MODE_RECORD, 100, 0, 0);
        queue_sample(10, 0, 0);
        queue_sample(200, 0, 0);
        queue_sample(1, 2, 3);
        queue_sample(4, 5, 6);

        // refractory samples drop without a motion test
        configure_capture(MODE_RECORD, 100, 1, 2);
        queue_sample(200, 0, 0);
        queue_sample(7, 7, 7);
        queue_sample(8, 8, 8);
        queue_sample(900, 0, 0);
        queue_sample(1, 1, 1);
        queue_sample(300, 0, 0);

        configure_capture(MODE_UNUSED, 100, 2, 2);
        queue_sample(30000, 0, 0);
        queue_sample(-32768, 32767, -32768);

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                md = MODE_STREAM; thr = 32767; wl = 65535; rf = 65535;
            end else if (p == 1) begin
                md = MODE_RECORD; thr = 500; wl = 65535; rf = 3;
            end else if (p == RAND_PHASES - 1) begin
                md = MODE_RECORD; thr = 1000; wl = 4; rf = 65535;
            end else begin
                sel = $urandom_range(0, 9);
                md  = (sel < 2) ? MODE_STREAM : (sel < 4) ? MODE_ABOVE :
                      (sel < 9) ? MODE_RECORD : MODE_UNUSED;
                sel = $urandom_range(0, 9);
                thr = (sel == 0) ? 0 : (sel == 1) ? 32767 : $urandom_range(200, 4000);
                sel = $urandom_range(0, 9);
                wl  = (sel == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
                sel = $urandom_range(0, 9);
                rf  = (sel < 3) ? 0 : $urandom_range(1, 8);
            end
            configure_capture(md, thr, wl, rf);
            split = (p == 2) || ($urandom_range(0, 2) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (split && i == ITEMS_PER_PHASE / 2) begin
                    wait_sent();
                    while (expected_caps.size() > 0) @(posedge aclk);
                end
                pending_samples.push_back(random_sample(thr));
            end
        end

        drain_captures();
        if (mismatches == 0 && expected_caps.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
